FILE: hdl/mpat_pkg.sv
// Package for the merging priority action table.
// Holds the entry type, operation and status codes, and the FSM state type.
// No dependencies.
package mpat_pkg;

  typedef enum logic [2:0] {
    FN_PUSH    = 3'd0,
    FN_POP     = 3'd1,
    FN_POP_ID  = 3'd2,
    FN_PEEK    = 3'd3,
    FN_EXPIRE  = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MODIFY,
    S_FINISH
  } state_e;

  // Relevance floor: -400.0 in Q16.8
  localparam logic signed [23:0] REL_FLOOR = -24'sd102400;

  typedef struct packed {
    logic [9:0]         action;
    logic signed [23:0] rel;
    logic [15:0]        event_tag;
    logic [31:0]        birth;
  } entry_t;

  typedef struct packed {
    logic load_in;   // take the request entry (append)
    logic feed;      // take the recirculated head entry
    logic shift;     // take the right neighbor's entry
  } cell_ctrl_t;

endpackage

FILE: hdl/merging_priority_action_table_unit.sv
// Merging priority action table: a chain of TABLE_DEPTH cells kept in insertion
// order, cell 0 the oldest. Push, pop, pop-by-id and peek rotate the held
// entries through the head of the chain, one entry per cycle, in a scan pass that
// finds the matching id or the best relevance above -400.0 (oldest wins ties); a
// second rotation then drops or merges the chosen entry. Expiry rotates once and
// drops every aged entry. A merging push, or a pop or pop-by-id that finds its
// entry, makes both rotations; an appending or dropped push, a peek or a miss only
// the scan; an expiry with a nonzero limit only the drop rotation; an unused code
// none. All rotations pass through the single head cell.
// One request is in work at a time; a finished result waits in the output
// register while the next request is accepted. expire_seconds is written on
// the cfg channel; the user must write it only while idle, since the block
// itself does not enforce this.
module merging_priority_action_table_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // func[2:0], action_id[12:3], relevance[36:13], event_id[52:37],
  // now_seconds[84:53], zero pad
  input  logic [87:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], out_action_id[11:2], out_relevance[35:12],
  // out_event_id[51:36], entry_total[56:52], zero pad
  output logic [63:0] m_axis_tdata
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  mpat_pkg::state_e st_q, st_d;

  logic [15:0] exp_q;
  logic [CW-1:0] cnt_q, stp_q, n0_q;

  // request fields
  logic [2:0]         op_func_q;
  logic [9:0]         op_id_q;
  logic signed [23:0] op_rel_q;
  logic [15:0]        op_ev_q;
  logic [31:0]        op_now_q;

  // scan record
  logic               found_q;
  logic [CW-1:0]      sel_q;
  mpat_pkg::entry_t   sel_ent_q;

  // pending result
  logic [1:0]         res_status_q;
  logic [9:0]         res_id_q;
  logic signed [23:0] res_rel_q;
  logic [15:0]        res_ev_q;

  logic               out_vld_q;
  logic [63:0]        out_data_q;

  mpat_pkg::entry_t cells [TABLE_DEPTH];
  mpat_pkg::entry_t head, feed, new_ent;

  logic accept, scan_step, mod_step, decide, finish_ld;
  logic last_step, keep, by_id, cnt_room;
  logic [CW-1:0] last_pos;
  logic [31:0] age;
  logic [CW+4:0] total_w;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign head     = cells[0];
  assign last_pos = cnt_q - 1'b1;
  assign last_step = (stp_q == n0_q - 1'b1);
  assign by_id    = (op_func_q == mpat_pkg::FN_PUSH) || (op_func_q == mpat_pkg::FN_POP_ID);
  assign cnt_room = (cnt_q < CW'(TABLE_DEPTH));
  assign age      = op_now_q - head.birth;
  assign cfg_ready_o = 1'b1;

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      mpat_pkg::S_IDLE: begin
        if (accept) begin
          case (s_axis_tdata[2:0])
            mpat_pkg::FN_PUSH, mpat_pkg::FN_POP, mpat_pkg::FN_POP_ID,
            mpat_pkg::FN_PEEK: begin
              st_d = (cnt_q == '0) ? mpat_pkg::S_DECIDE : mpat_pkg::S_SCAN;
            end
            mpat_pkg::FN_EXPIRE: begin
              st_d = (exp_q != '0 && cnt_q != '0) ? mpat_pkg::S_MODIFY
                                                   : mpat_pkg::S_FINISH;
            end
            default: st_d = mpat_pkg::S_FINISH;
          endcase
        end
      end
      mpat_pkg::S_SCAN: begin
        if (last_step) st_d = mpat_pkg::S_DECIDE;
      end
      mpat_pkg::S_DECIDE: begin
        if (found_q && op_func_q != mpat_pkg::FN_PEEK) st_d = mpat_pkg::S_MODIFY;
        else st_d = mpat_pkg::S_FINISH;
      end
      mpat_pkg::S_MODIFY: begin
        if (last_step) st_d = mpat_pkg::S_FINISH;
      end
      mpat_pkg::S_FINISH: begin
        if (!out_vld_q || m_axis_tready) st_d = mpat_pkg::S_IDLE;
      end
      default: st_d = mpat_pkg::S_IDLE;
    endcase
  end

  // State decoded controls
  always_comb begin
    s_axis_tready = 1'b0;
    scan_step     = 1'b0;
    mod_step      = 1'b0;
    decide        = 1'b0;
    finish_ld     = 1'b0;
    case (st_q)
      mpat_pkg::S_IDLE:   s_axis_tready = 1'b1;
      mpat_pkg::S_SCAN:   scan_step     = 1'b1;
      mpat_pkg::S_DECIDE: decide        = 1'b1;
      mpat_pkg::S_MODIFY: mod_step      = 1'b1;
      mpat_pkg::S_FINISH: finish_ld     = !out_vld_q || m_axis_tready;
      default: ;
    endcase
  end

  // Head handling during the modify rotation: merge, drop or keep.
  // During the scan the head recirculates untouched.
  always_comb begin
    feed = head;
    keep = 1'b1;
    case (op_func_q)
      mpat_pkg::FN_PUSH: begin
        if (mod_step && stp_q == sel_q && head.rel < op_rel_q) begin
          feed.rel       = op_rel_q;
          feed.event_tag = op_ev_q;
        end
      end
      mpat_pkg::FN_POP, mpat_pkg::FN_POP_ID: keep = !(stp_q == sel_q);
      mpat_pkg::FN_EXPIRE: keep = !(age > {16'd0, exp_q});
      default: ;
    endcase
  end

  assign new_ent = '{action: op_id_q, rel: op_rel_q, event_tag: op_ev_q, birth: op_now_q};

  // The cell chain
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    mpat_pkg::cell_ctrl_t ctrl;
    mpat_pkg::entry_t     nbr;
    assign ctrl.shift   = (scan_step || mod_step) && (CW'(i) < last_pos);
    assign ctrl.feed    = (scan_step || (mod_step && keep)) && (CW'(i) == last_pos);
    assign ctrl.load_in = decide && !found_q && op_func_q == mpat_pkg::FN_PUSH &&
                          cnt_room && (CW'(i) == cnt_q);
    if (i == TABLE_DEPTH - 1) begin : g_end
      assign nbr = cells[i];
    end else begin : g_mid
      assign nbr = cells[i+1];
    end
    mpat_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .nbr_i   (nbr),
      .feed_i  (feed),
      .new_i   (new_ent),
      .entry_o (cells[i])
    );
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= mpat_pkg::S_IDLE;
      cnt_q     <= '0;
      exp_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i) exp_q <= cfg_data_i;
      if (decide && !found_q && op_func_q == mpat_pkg::FN_PUSH && cnt_room) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (mod_step && !keep) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (finish_ld) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
    end
  end

  assign total_w = {5'd0, cnt_q};

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_func_q    <= s_axis_tdata[2:0];
      op_id_q      <= s_axis_tdata[12:3];
      op_rel_q     <= s_axis_tdata[36:13];
      op_ev_q      <= s_axis_tdata[52:37];
      op_now_q     <= s_axis_tdata[84:53];
      found_q      <= 1'b0;
      sel_q        <= '0;
      sel_ent_q.rel <= mpat_pkg::REL_FLOOR;
      stp_q        <= '0;
      n0_q         <= cnt_q;
      res_status_q <= mpat_pkg::ST_OK;
      res_id_q     <= '0;
      res_rel_q    <= '0;
      res_ev_q     <= '0;
    end
    if (scan_step) begin
      stp_q <= stp_q + 1'b1;
      if (by_id) begin
        if (!found_q && head.action == op_id_q) begin
          found_q   <= 1'b1;
          sel_q     <= stp_q;
          sel_ent_q <= head;
        end
      end else if (head.rel > sel_ent_q.rel) begin
        found_q   <= 1'b1;
        sel_q     <= stp_q;
        sel_ent_q <= head;
      end
    end
    if (decide) begin
      stp_q <= '0;
      n0_q  <= cnt_q;
      if (found_q) begin
        res_status_q <= mpat_pkg::ST_OK;
        res_id_q     <= sel_ent_q.action;
        if (op_func_q == mpat_pkg::FN_PUSH && sel_ent_q.rel < op_rel_q) begin
          res_rel_q <= op_rel_q;
          res_ev_q  <= op_ev_q;
        end else begin
          res_rel_q <= sel_ent_q.rel;
          res_ev_q  <= sel_ent_q.event_tag;
        end
      end else if (op_func_q == mpat_pkg::FN_PUSH && cnt_room) begin
        res_status_q <= mpat_pkg::ST_OK;
        res_id_q     <= op_id_q;
        res_rel_q    <= op_rel_q;
        res_ev_q     <= op_ev_q;
      end else begin
        res_status_q <= (op_func_q == mpat_pkg::FN_PUSH) ? mpat_pkg::ST_FULL
                                                         : mpat_pkg::ST_EMPTY;
      end
    end
    if (mod_step) stp_q <= stp_q + 1'b1;
    if (finish_ld) begin
      out_data_q <= {7'd0, total_w[4:0], res_ev_q, res_rel_q, res_id_q, res_status_q};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // Table never holds more than its depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TABLE_DEPTH)) else $error("entry count above depth");

  // Scan rotation leaves the count alone
  a_scan_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == mpat_pkg::S_SCAN |=> $stable(cnt_q)) else $error("count moved in scan");

  // Modify rotation only runs over a non-empty table
  a_mod_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == mpat_pkg::S_MODIFY |-> cnt_q != '0) else $error("modify on empty table");

endmodule

FILE: hdl/mpat_cell.sv
// One storage cell of the action table chain.
// Depends on mpat_pkg (entry_t, cell_ctrl_t).
module mpat_cell (
  input  logic                clk_i,
  input  mpat_pkg::cell_ctrl_t ctrl_i,
  input  mpat_pkg::entry_t    nbr_i,
  input  mpat_pkg::entry_t    feed_i,
  input  mpat_pkg::entry_t    new_i,
  output mpat_pkg::entry_t    entry_o
);

  mpat_pkg::entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load_in) begin
      entry_d = new_i;
    end else if (ctrl_i.feed) begin
      entry_d = feed_i;
    end else if (ctrl_i.shift) begin
      entry_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
